FILE: design/esc_pkg.sv
`timescale 1ns / 1ps
// esc_pkg: widths, calendar constants, reciprocal multipliers and stage indexes
// for the epoch-seconds to calendar pipeline; depends on nothing else

package esc_pkg;

  // width of the signed seconds input, 33..64
  localparam int SECONDS_WIDTH = 40;

  localparam int DAY_SECONDS   = 86400;
  localparam int DAYS_PER_ERA  = 146097;
  localparam int YEARS_PER_ERA = 400;
  localparam int SIXTY         = 60;
  localparam int DAYS_TO_EPOCH = 719468;  // 0000-03-01 to 1970-01-01
  localparam int DAYS_4Y       = 1460;
  localparam int DAYS_100Y     = 36524;
  localparam int DAYS_400Y     = DAYS_PER_ERA - 1;
  localparam int DAYS_PER_YEAR = 365;
  localparam int DAYS_PER_WEEK = 7;
  localparam int MONTHS        = 12;
  localparam int YEAR_MAX      = 32767;
  localparam int YEAR_MIN      = -32768;

  // shifted time, its magnitude, and the seconds-of-era remainder
  localparam int TW    = ((SECONDS_WIDTH > 37) ? SECONDS_WIDTH : 37) + 1;
  localparam int UW    = TW - 1;
  localparam int SOE_W = 34;
  localparam int QB    = UW - (SOE_W - 1);  // quotient bits, one per stage
  localparam int EW    = QB + 1;
  localparam int YW    = (EW + 10 > 17) ? EW + 10 : 17;

  localparam longint EPOCH_SHIFT_SECS = longint'(DAYS_TO_EPOCH) * longint'(DAY_SECONDS);
  localparam logic [SOE_W-1:0] ERA_SECS =
      SOE_W'(longint'(DAYS_PER_ERA) * longint'(DAY_SECONDS));

  // 86400 = 128 * 675
  localparam int DAY_SHIFT = 7;
  localparam int DAY_ODD   = DAY_SECONDS / (1 << DAY_SHIFT);
  localparam int SOE_HI_W  = SOE_W - DAY_SHIFT;
  localparam int REM_W     = $clog2(DAY_ODD);
  localparam int SOD_W     = REM_W + DAY_SHIFT;
  localparam int DOE_W     = 18;
  localparam int MINS_W    = 11;
  localparam int YOE_W     = 9;
  localparam int DOY_W     = 9;

  // floor(x / d) = (x * m) >> s, exact for x below 2**n with s = n + clog2(d)
  localparam int     R675_S  = SOE_HI_W + $clog2(DAY_ODD);
  localparam longint R675_M  = ((longint'(1) << R675_S) + DAY_ODD - 1) / DAY_ODD;
  localparam int     P675_W  = SOE_HI_W + $clog2(R675_M + 1);

  localparam int     R4Y_S   = DOE_W + $clog2(DAYS_4Y);
  localparam longint R4Y_M   = ((longint'(1) << R4Y_S) + DAYS_4Y - 1) / DAYS_4Y;
  localparam int     P4Y_W   = DOE_W + $clog2(R4Y_M + 1);

  localparam int     R7_S    = DOE_W + $clog2(DAYS_PER_WEEK);
  localparam longint R7_M    = ((longint'(1) << R7_S) + DAYS_PER_WEEK - 1) / DAYS_PER_WEEK;
  localparam int     P7_W    = DOE_W + $clog2(R7_M + 1);

  localparam int     R60A_S  = SOD_W + $clog2(SIXTY);
  localparam longint R60A_M  = ((longint'(1) << R60A_S) + SIXTY - 1) / SIXTY;
  localparam int     P60A_W  = SOD_W + $clog2(R60A_M + 1);

  localparam int     R60B_S  = MINS_W + $clog2(SIXTY);
  localparam longint R60B_M  = ((longint'(1) << R60B_S) + SIXTY - 1) / SIXTY;
  localparam int     P60B_W  = MINS_W + $clog2(R60B_M + 1);

  localparam int     R365_S  = DOE_W + $clog2(DAYS_PER_YEAR);
  localparam longint R365_M  = ((longint'(1) << R365_S) + DAYS_PER_YEAR - 1) / DAYS_PER_YEAR;
  localparam int     P365_W  = DOE_W + $clog2(R365_M + 1);

  // stage indexes
  localparam int ST_PREP  = 0;
  localparam int ST_DIV0  = 1;
  localparam int ST_ERA   = QB + 1;
  localparam int ST_DAY   = QB + 2;
  localparam int ST_SPLIT = QB + 3;
  localparam int ST_CENT  = QB + 4;
  localparam int ST_YEAR  = QB + 5;
  localparam int ST_DOY   = QB + 6;
  localparam int ST_MONTH = QB + 7;
  localparam int ST_OUT   = QB + 8;
  localparam int NS       = QB + 9;

  // first day of each month in a year that starts on march 1
  function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: design/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// epoch_seconds_to_calendar: pipelined conversion of signed unix seconds to
// proleptic gregorian calendar fields; depends on esc_pkg
//
// Takes one signed timestamp per cycle while in_ready is high and returns
// second, minute, hour, 12-hour clock, day, month, weekday (sunday is 1) and
// full year, with floor semantics so times before 1970 convert correctly.
// Throughput is one transaction per clock while out_ready is high; the pipeline
// is an input register, one era-division stage per quotient bit, then eight
// stages of day and time-of-day splitting. Every stage holds its own valid bit,
// so empty stages keep filling while a finished result waits on out_ready.
// Years beyond 16 bits saturate.

module epoch_seconds_to_calendar (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [esc_pkg::SECONDS_WIDTH-1:0]  epoch_seconds,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [5:0]                                second,
  output logic [5:0]                                minute,
  output logic [4:0]                                hour,
  output logic [3:0]                                hour_twelve,
  output logic                                      is_pm,
  output logic [4:0]                                day_of_month,
  output logic [3:0]                                month,
  output logic [2:0]                                weekday,
  output logic signed [15:0]                        calendar_year
);

  typedef struct packed {
    logic                     neg;
    logic [esc_pkg::UW-1:0]   mag;
  } prep_t;

  typedef struct packed {
    logic                      neg;
    logic [esc_pkg::SOE_W-1:0] rem;
    logic [esc_pkg::QB-1:0]    low;
    logic [esc_pkg::QB-1:0]    quo;
  } div_stage_t;

  typedef struct packed {
    logic [esc_pkg::SOE_W-1:0] soe;
    logic [esc_pkg::EW-1:0]    era;
  } era_t;

  typedef struct packed {
    logic [esc_pkg::P675_W-1:0]    prod;
    logic [esc_pkg::SOE_HI_W-1:0]  soe_hi;
    logic [esc_pkg::DAY_SHIFT-1:0] soe_lo;
    logic [esc_pkg::YW-1:0]        era400;
  } day_t;

  typedef struct packed {
    logic [esc_pkg::DOE_W-1:0] doe;
    logic [esc_pkg::SOD_W-1:0] sod;
    logic [esc_pkg::P4Y_W-1:0] p4y;
    logic [esc_pkg::P7_W-1:0]  p7;
    logic [esc_pkg::YW-1:0]    era400;
  } split_t;

  typedef struct packed {
    logic [esc_pkg::DOE_W-1:0]  num;
    logic [esc_pkg::P60A_W-1:0] pmins;
    logic [esc_pkg::SOD_W-1:0]  sod;
    logic [esc_pkg::DOE_W-1:0]  doe;
    logic [2:0]                 wd;
    logic [esc_pkg::YW-1:0]     era400;
  } cent_t;

  typedef struct packed {
    logic [esc_pkg::P365_W-1:0] pyoe;
    logic [esc_pkg::MINS_W-1:0] mins;
    logic [5:0]                 sec;
    logic [esc_pkg::P60B_W-1:0] phr;
    logic [esc_pkg::DOE_W-1:0]  doe;
    logic [2:0]                 wd;
    logic [esc_pkg::YW-1:0]     era400;
  } year_t;

  typedef struct packed {
    logic [esc_pkg::YOE_W-1:0] yoe;
    logic [esc_pkg::DOY_W-1:0] doy;
    logic [5:0]                sec;
    logic [5:0]                mn;
    logic [4:0]                hr;
    logic [3:0]                h12;
    logic                      pm;
    logic [2:0]                wd;
    logic [esc_pkg::YW-1:0]    era400;
  } doy_t;

  typedef struct packed {
    logic [3:0]                mp;
    logic [esc_pkg::YOE_W-1:0] yoe;
    logic [esc_pkg::DOY_W-1:0] doy;
    logic [5:0]                sec;
    logic [5:0]                mn;
    logic [4:0]                hr;
    logic [3:0]                h12;
    logic                      pm;
    logic [2:0]                wd;
    logic [esc_pkg::YW-1:0]    era400;
  } month_t;

  logic [esc_pkg::NS-1:0] valid;
  logic [esc_pkg::NS-1:0] en;

  prep_t      prep, prep_next;
  div_stage_t div_first;
  div_stage_t div_in [1:esc_pkg::QB];
  div_stage_t div_r  [1:esc_pkg::QB];
  era_t       era_r, era_next;
  day_t       day_r, day_next;
  split_t     split_r, split_next;
  cent_t      cent_r, cent_next;
  year_t      year_r, year_next;
  doy_t       doy_r, doy_next;
  month_t     month_r, month_next;

  logic [esc_pkg::TW-1:0]       t_ext;
  logic [esc_pkg::TW-1:0]       t_shift;
  logic [esc_pkg::YW-1:0]       era_ext;
  logic [esc_pkg::SOE_HI_W-1:0] rem675;
  logic [esc_pkg::DOE_W-1:0]    doe3;
  logic [esc_pkg::DOE_W-1:0]    q4y;
  logic [esc_pkg::DOE_W-1:0]    q100y;
  logic [esc_pkg::DOE_W-1:0]    q400y;
  logic [esc_pkg::DOE_W-1:0]    q7;
  logic [esc_pkg::DOE_W-1:0]    wd0;
  logic [esc_pkg::SOD_W-1:0]    sec_full;
  logic [esc_pkg::DOE_W-1:0]    q100;
  logic [esc_pkg::DOE_W-1:0]    doy_full;
  logic [esc_pkg::MINS_W-1:0]   mn_full;
  logic [esc_pkg::DOY_W-1:0]    dom_full;
  logic [esc_pkg::YW-1:0]       year_full;
  logic [15:0]                  year_sat;
  logic [3:0]                   mon;

  // a stage may load when it or any stage after it is empty, or the output drains
  always_comb begin
    for (int k = 0; k < esc_pkg::NS; k++) begin
      en[k] = out_ready | (|(~valid & ({esc_pkg::NS{1'b1}} << k)));
    end
  end

  assign in_ready  = en[esc_pkg::ST_PREP];
  assign out_valid = valid[esc_pkg::NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= (en & {valid[esc_pkg::NS-2:0], in_valid}) | (~en & valid);
    end
  end

  // shift the origin to 0000-03-01 and fold negatives onto their complement
  always_comb begin
    t_ext = {{(esc_pkg::TW - esc_pkg::SECONDS_WIDTH){epoch_seconds[esc_pkg::SECONDS_WIDTH-1]}},
             epoch_seconds};
    t_shift = t_ext + esc_pkg::TW'(esc_pkg::EPOCH_SHIFT_SECS);
    prep_next.neg = t_shift[esc_pkg::TW-1];
    prep_next.mag = t_shift[esc_pkg::TW-1] ? ~t_shift[esc_pkg::UW-1:0]
                                           : t_shift[esc_pkg::UW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[esc_pkg::ST_PREP]) begin
      prep <= prep_next;
    end
  end

  // restoring division by the seconds in one 400-year era
  always_comb begin
    div_first.neg = prep.neg;
    div_first.rem = {{(esc_pkg::SOE_W - (esc_pkg::UW - esc_pkg::QB)){1'b0}},
                     prep.mag[esc_pkg::UW-1:esc_pkg::QB]};
    div_first.low = prep.mag[esc_pkg::QB-1:0];
    div_first.quo = '0;
  end

  for (genvar i = 1; i <= esc_pkg::QB; i++) begin : g_div
    logic [esc_pkg::SOE_W:0] trial;
    logic [esc_pkg::SOE_W:0] diff;
    div_stage_t              nxt;

    if (i == 1) begin : g_head
      assign div_in[i] = div_first;
    end else begin : g_link
      assign div_in[i] = div_r[i-1];
    end

    always_comb begin
      trial = {div_in[i].rem, div_in[i].low[esc_pkg::QB-i]};
      diff  = trial - {1'b0, esc_pkg::ERA_SECS};
      nxt   = div_in[i];
      if (trial >= {1'b0, esc_pkg::ERA_SECS}) begin
        nxt.rem                 = diff[esc_pkg::SOE_W-1:0];
        nxt.quo[esc_pkg::QB-i]  = 1'b1;
      end else begin
        nxt.rem = trial[esc_pkg::SOE_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[esc_pkg::ST_DIV0+i-1]) begin
        div_r[i] <= nxt;
      end
    end
  end

  // undo the complement: floor quotient and non-negative remainder
  always_comb begin
    era_next.soe = div_r[esc_pkg::QB].neg
                 ? (esc_pkg::ERA_SECS - esc_pkg::SOE_W'(1)) - div_r[esc_pkg::QB].rem
                 : div_r[esc_pkg::QB].rem;
    era_next.era = div_r[esc_pkg::QB].neg ? ~{1'b0, div_r[esc_pkg::QB].quo}
                                          : {1'b0, div_r[esc_pkg::QB].quo};
  end

  always_ff @(posedge clk) begin
    if (en[esc_pkg::ST_ERA]) begin
      era_r <= era_next;
    end
  end

  // day of era = (soe >> 7) / 675
  always_comb begin
    era_ext = {{(esc_pkg::YW - esc_pkg::EW){era_r.era[esc_pkg::EW-1]}}, era_r.era};
    day_next.era400 = era_ext * esc_pkg::YW'(esc_pkg::YEARS_PER_ERA);
    day_next.soe_hi = era_r.soe[esc_pkg::SOE_W-1:esc_pkg::DAY_SHIFT];
    day_next.soe_lo = era_r.soe[esc_pkg::DAY_SHIFT-1:0];
    day_next.prod   = esc_pkg::P675_W'(era_r.soe[esc_pkg::SOE_W-1:esc_pkg::DAY_SHIFT])
                    * esc_pkg::P675_W'(esc_pkg::R675_M);
  end

  always_ff @(posedge clk) begin
    if (en[esc_pkg::ST_DAY]) begin
      day_r <= day_next;
    end
  end

  always_comb begin
    split_next.doe    = esc_pkg::DOE_W'(day_r.prod >> esc_pkg::R675_S);
    rem675            = day_r.soe_hi - esc_pkg::SOE_HI_W'(split_next.doe)
                      * esc_pkg::SOE_HI_W'(esc_pkg::DAY_ODD);
    split_next.sod    = {rem675[esc_pkg::REM_W-1:0], day_r.soe_lo};
    split_next.p4y    = esc_pkg::P4Y_W'(split_next.doe) * esc_pkg::P4Y_W'(esc_pkg::R4Y_M);
    // day of era 0 is a wednesday
    doe3              = split_next.doe + esc_pkg::DOE_W'(3);
    split_next.p7     = esc_pkg::P7_W'(doe3) * esc_pkg::P7_W'(esc_pkg::R7_M);
    split_next.era400 = day_r.era400;
  end

  always_ff @(posedge clk) begin
    if (en[esc_pkg::ST_SPLIT]) begin
      split_r <= split_next;
    end
  end

  // leap-day corrections ahead of the year divide, weekday
  always_comb begin
    q4y   = esc_pkg::DOE_W'(split_r.p4y >> esc_pkg::R4Y_S);
    q100y = esc_pkg::DOE_W'(split_r.doe >= esc_pkg::DOE_W'(esc_pkg::DAYS_100Y))
          + esc_pkg::DOE_W'(split_r.doe >= esc_pkg::DOE_W'(2 * esc_pkg::DAYS_100Y))
          + esc_pkg::DOE_W'(split_r.doe >= esc_pkg::DOE_W'(3 * esc_pkg::DAYS_100Y))
          + esc_pkg::DOE_W'(split_r.doe >= esc_pkg::DOE_W'(4 * esc_pkg::DAYS_100Y));
    q400y = esc_pkg::DOE_W'(split_r.doe >= esc_pkg::DOE_W'(esc_pkg::DAYS_400Y));
    cent_next.num = split_r.doe - q4y + q100y - q400y;
    cent_next.pmins = esc_pkg::P60A_W'(split_r.sod) * esc_pkg::P60A_W'(esc_pkg::R60A_M);
    q7  = esc_pkg::DOE_W'(split_r.p7 >> esc_pkg::R7_S);
    wd0 = (split_r.doe + esc_pkg::DOE_W'(3))
        - q7 * esc_pkg::DOE_W'(esc_pkg::DAYS_PER_WEEK);
    cent_next.wd     = wd0[2:0] + 3'd1;
    cent_next.sod    = split_r.sod;
    cent_next.doe    = split_r.doe;
    cent_next.era400 = split_r.era400;
  end

  always_ff @(posedge clk) begin
    if (en[esc_pkg::ST_CENT]) begin
      cent_r <= cent_next;
    end
  end

  always_comb begin
    year_next.pyoe = esc_pkg::P365_W'(cent_r.num) * esc_pkg::P365_W'(esc_pkg::R365_M);
    year_next.mins = esc_pkg::MINS_W'(cent_r.pmins >> esc_pkg::R60A_S);
    sec_full       = cent_r.sod - esc_pkg::SOD_W'(year_next.mins)
                   * esc_pkg::SOD_W'(esc_pkg::SIXTY);
    year_next.sec  = sec_full[5:0];
    year_next.phr  = esc_pkg::P60B_W'(year_next.mins) * esc_pkg::P60B_W'(esc_pkg::R60B_M);
    year_next.doe    = cent_r.doe;
    year_next.wd     = cent_r.wd;
    year_next.era400 = cent_r.era400;
  end

  always_ff @(posedge clk) begin
    if (en[esc_pkg::ST_YEAR]) begin
      year_r <= year_next;
    end
  end

  // day of the march-based year, hour and minute
  always_comb begin
    doy_next.yoe = esc_pkg::YOE_W'(year_r.pyoe >> esc_pkg::R365_S);
    q100 = esc_pkg::DOE_W'(doy_next.yoe >= esc_pkg::YOE_W'(100))
         + esc_pkg::DOE_W'(doy_next.yoe >= esc_pkg::YOE_W'(200))
         + esc_pkg::DOE_W'(doy_next.yoe >= esc_pkg::YOE_W'(300));
    doy_full = year_r.doe
             - (esc_pkg::DOE_W'(doy_next.yoe) * esc_pkg::DOE_W'(esc_pkg::DAYS_PER_YEAR)
                + esc_pkg::DOE_W'(doy_next.yoe[esc_pkg::YOE_W-1:2]) - q100);
    doy_next.doy = doy_full[esc_pkg::DOY_W-1:0];
    doy_next.hr  = 5'(year_r.phr >> esc_pkg::R60B_S);
    mn_full      = year_r.mins - esc_pkg::MINS_W'(doy_next.hr)
                 * esc_pkg::MINS_W'(esc_pkg::SIXTY);
    doy_next.mn  = mn_full[5:0];
    doy_next.pm  = (doy_next.hr >= 5'd12);
    if (doy_next.hr == 5'd0) begin
      doy_next.h12 = 4'd12;
    end else if (doy_next.hr > 5'd12) begin
      doy_next.h12 = 4'(doy_next.hr - 5'd12);
    end else begin
      doy_next.h12 = doy_next.hr[3:0];
    end
    doy_next.sec    = year_r.sec;
    doy_next.wd     = year_r.wd;
    doy_next.era400 = year_r.era400;
  end

  always_ff @(posedge clk) begin
    if (en[esc_pkg::ST_DOY]) begin
      doy_r <= doy_next;
    end
  end

  // month index from march: count month starts already passed
  always_comb begin
    month_next.mp = 4'd0;
    for (int k = 1; k < esc_pkg::MONTHS; k++) begin
      if (doy_r.doy >= esc_pkg::month_start(4'(k))) begin
        month_next.mp = month_next.mp + 4'd1;
      end
    end
    month_next.yoe    = doy_r.yoe;
    month_next.doy    = doy_r.doy;
    month_next.sec    = doy_r.sec;
    month_next.mn     = doy_r.mn;
    month_next.hr     = doy_r.hr;
    month_next.h12    = doy_r.h12;
    month_next.pm     = doy_r.pm;
    month_next.wd     = doy_r.wd;
    month_next.era400 = doy_r.era400;
  end

  always_ff @(posedge clk) begin
    if (en[esc_pkg::ST_MONTH]) begin
      month_r <= month_next;
    end
  end

  // january and february belong to the following calendar year
  always_comb begin
    dom_full  = month_r.doy - esc_pkg::month_start(month_r.mp) + esc_pkg::DOY_W'(1);
    mon       = (month_r.mp < 4'd10) ? month_r.mp + 4'd3 : month_r.mp - 4'd9;
    year_full = month_r.era400 + esc_pkg::YW'(month_r.yoe)
              + esc_pkg::YW'(month_r.mp >= 4'd10);
    if ($signed(year_full) > $signed(esc_pkg::YW'(esc_pkg::YEAR_MAX))) begin
      year_sat = 16'(esc_pkg::YEAR_MAX);
    end else if ($signed(year_full) < $signed(esc_pkg::YW'(esc_pkg::YEAR_MIN))) begin
      year_sat = 16'(esc_pkg::YEAR_MIN);
    end else begin
      year_sat = year_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[esc_pkg::ST_OUT]) begin
      second        <= month_r.sec;
      minute        <= month_r.mn;
      hour          <= month_r.hr;
      hour_twelve   <= month_r.h12;
      is_pm         <= month_r.pm;
      day_of_month  <= dom_full[4:0];
      month         <= mon;
      weekday       <= month_r.wd;
      calendar_year <= year_sat;
    end
  end

  a_drain_accepts: assert property (@(posedge clk) disable iff (rst)
      out_ready |-> in_ready)
    else $error("input stalled while the output drains");

  a_bubble_accepts: assert property (@(posedge clk) disable iff (rst)
      !(&valid) |-> in_ready)
    else $error("input stalled with an empty stage in the pipeline");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (second < 6'd60 && minute < 6'd60 && hour < 5'd24))
    else $error("time of day out of range");

  a_twelve_hour: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (is_pm == (hour >= 5'd12) && hour_twelve >= 4'd1
                     && hour_twelve <= 4'd12))
    else $error("12-hour fields disagree with hour");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (day_of_month != 5'd0 && month >= 4'd1 && month <= 4'd12
                     && weekday != 3'd0))
    else $error("date fields out of range");

endmodule
